FILE: hw/rtl/ssrt_pkg.sv
// ----------------------------------------------------------------------------
// Slot reservation table package
// Shared constants, word types and helper functions for the slot table.
// ----------------------------------------------------------------------------
package ssrt_pkg;

  localparam int SLOT_DEPTH = 256;
  localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
  localparam int CNT_W      = $clog2(SLOT_DEPTH + 1);

  localparam int COORD_W = 24;
  localparam int IDX_W   = 8;
  localparam int CFG_W   = 9;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int DIST_W  = SQ_W + 2;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_FIND    = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NONE     = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_WAS_FREE = 2'd3;

  typedef struct packed {
    logic [1:0]                command;
    logic [IDX_W-1:0]          entry_index;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [COORD_W-1:0]        max_distance;
    logic                      set_mark;
  } req_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [IDX_W-1:0]          found_index;
    logic signed [COORD_W-1:0] found_x;
    logic signed [COORD_W-1:0] found_y;
    logic signed [COORD_W-1:0] found_z;
  } rsp_t;

  // One table entry as it sits in memory.
  typedef struct packed {
    logic                      mark;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Travels with each scan read down the distance pipeline.
  typedef struct packed {
    logic [SLOT_AW-1:0] pos;
    logic               last;
  } scan_tag_t;

  function automatic logic [CNT_W-1:0] active_count(input logic [CFG_W-1:0] n);
    if (32'(n) > 32'(SLOT_DEPTH)) begin
      return CNT_W'(SLOT_DEPTH);
    end
    return CNT_W'(n);
  endfunction

  // Magnitude of a difference of two coordinates; it always fits 24 bits.
  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    logic [COORD_W:0] d;
    logic [COORD_W:0] m;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    m = d[COORD_W] ? (~d + 1'b1) : d;
    return m[COORD_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/ssrt_ram.sv
// ----------------------------------------------------------------------------
// Slot table RAM
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module ssrt_ram #(
  parameter int  WIDTH  = 8,
  parameter int  DEPTH  = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/ssrt_dist.sv
// ----------------------------------------------------------------------------
// Slot distance pipeline
// Two registered stages: coordinate differences, then their squares. The
// squared distance of each scanned slot comes out as a sum of the squares.
// ----------------------------------------------------------------------------
module ssrt_dist import ssrt_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      flush,
  input  logic                      in_valid,
  input  scan_tag_t                 in_tag,
  input  slot_t                     in_slot,
  input  logic signed [COORD_W-1:0] query_x,
  input  logic signed [COORD_W-1:0] query_y,
  input  logic signed [COORD_W-1:0] query_z,
  output logic                      out_valid,
  output scan_tag_t                 out_tag,
  output slot_t                     out_slot,
  output logic [DIST_W-1:0]         out_dist
);

  logic               valid_a;
  scan_tag_t          tag_a;
  slot_t              slot_a;
  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;
  logic [COORD_W-1:0] dz;

  logic               valid_b;
  scan_tag_t          tag_b;
  slot_t              slot_b;
  logic [SQ_W-1:0]    sq_x;
  logic [SQ_W-1:0]    sq_y;
  logic [SQ_W-1:0]    sq_z;

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
    end else begin
      valid_a <= in_valid;
      valid_b <= valid_a;
    end
    tag_a  <= in_tag;
    slot_a <= in_slot;
    dx     <= abs_diff(in_slot.x, query_x);
    dy     <= abs_diff(in_slot.y, query_y);
    dz     <= abs_diff(in_slot.z, query_z);
    tag_b  <= tag_a;
    slot_b <= slot_a;
    sq_x   <= dx * dx;
    sq_y   <= dy * dy;
    sq_z   <= dz * dz;
  end

  assign out_valid = valid_b;
  assign out_tag   = tag_b;
  assign out_slot  = slot_b;
  assign out_dist  = DIST_W'(sq_x) + DIST_W'(sq_y) + DIST_W'(sq_z);

endmodule

FILE: hw/rtl/spatial_slot_reservation_table.sv
// ----------------------------------------------------------------------------
// Spatial slot reservation table
// Table of point slots with busy marks; load, find-first-free and release.
// ----------------------------------------------------------------------------
// Usage: request words enter on req_valid / req_stall and each gives exactly
// one response word on rsp_valid / rsp_stall. The user must write the
// entry_count register through cfg_valid / cfg_ready only while the table is
// idle; the block itself does not enforce this.
// One request is handled at a time; req_stall stays high until its response
// is handed to the output register. A load and every rejected request pass
// through S_DONE before the next request, a release through S_REL and S_DONE.
// A find reads one slot per cycle from the slot RAM and scans at most the
// active count of slots, where the active count is entry_count capped at
// SLOT_DEPTH; each read passes the registered RAM read and the two-stage
// distance pipeline behind it.
// The output register lets the next request be accepted while a response
// waits on rsp_stall; a finished request only waits if that register is
// still occupied.
// After reset the block sweeps the slot RAM to clear all busy marks, with
// req_stall high; configuration writes are taken during that time.
// ----------------------------------------------------------------------------
module spatial_slot_reservation_table import ssrt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req_word,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp_word
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_REL   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t             state;
  logic [SLOT_AW-1:0] clr_addr;
  logic [CFG_W-1:0]   entry_count;
  req_t               item;
  logic [SQ_W-1:0]    limit;
  logic [SLOT_AW-1:0] issue_pos;
  logic [CNT_W-1:0]   issue_left;
  logic               rd_valid;
  scan_tag_t          rd_tag;
  rsp_t               res;

  logic [CNT_W-1:0]   count;
  logic               accept;
  logic               idx_ok;
  logic               load_ok;
  logic [SQ_W-1:0]    radius_sq;
  logic               issue_v;
  logic [SLOT_AW-1:0] issue_pos_next;
  logic               hit;
  logic               miss_end;
  logic               finish;
  logic               rsp_load;

  logic               ram_we;
  logic [SLOT_AW-1:0] ram_waddr;
  slot_t              ram_wdata;
  logic [SLOT_AW-1:0] ram_raddr;
  slot_t              ram_rdata;

  logic               d_valid;
  scan_tag_t          d_tag;
  slot_t              d_slot;
  logic [DIST_W-1:0]  d_dist;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  assign count     = active_count(entry_count);
  assign idx_ok    = 32'(req_word.entry_index) < 32'(count);
  assign load_ok   = 32'(req_word.entry_index) < 32'(SLOT_DEPTH);
  assign radius_sq = req_word.max_distance * req_word.max_distance;

  // A slot is taken when it is free and, with the filter on, within reach.
  assign hit      = d_valid && !d_slot.mark &&
                    ((item.max_distance == '0) || (d_dist <= DIST_W'(limit)));
  assign miss_end = d_valid && d_tag.last && !hit;
  assign finish   = hit || miss_end;
  assign issue_v  = (state == S_SCAN) && (issue_left != '0) && !finish;
  assign rsp_load = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  assign issue_pos_next = (32'(issue_pos) + 1 == 32'(count)) ? '0 : issue_pos + 1'b1;

  always_comb begin
    ram_raddr = (state == S_SCAN) ? issue_pos : SLOT_AW'(req_word.entry_index);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        if (accept && (req_word.command == CMD_LOAD) && load_ok) begin
          ram_we         = 1'b1;
          ram_waddr      = SLOT_AW'(req_word.entry_index);
          ram_wdata.mark = 1'b0;
          ram_wdata.x    = req_word.point_x;
          ram_wdata.y    = req_word.point_y;
          ram_wdata.z    = req_word.point_z;
        end
      end
      S_SCAN: begin
        if (hit && item.set_mark) begin
          ram_we         = 1'b1;
          ram_waddr      = d_tag.pos;
          ram_wdata      = d_slot;
          ram_wdata.mark = 1'b1;
        end
      end
      S_REL: begin
        ram_we         = 1'b1;
        ram_waddr      = SLOT_AW'(item.entry_index);
        ram_wdata      = ram_rdata;
        ram_wdata.mark = 1'b0;
      end
      S_DONE: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ssrt_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOT_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ssrt_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .flush     (finish || (state != S_SCAN)),
    .in_valid  (rd_valid),
    .in_tag    (rd_tag),
    .in_slot   (ram_rdata),
    .query_x   (item.point_x),
    .query_y   (item.point_y),
    .query_z   (item.point_z),
    .out_valid (d_valid),
    .out_tag   (d_tag),
    .out_slot  (d_slot),
    .out_dist  (d_dist)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      entry_count <= '0;
      issue_left  <= '0;
      rd_valid    <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        entry_count <= cfg_data;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      rd_valid <= issue_v;
      rd_tag   <= '{pos: issue_pos, last: (issue_left == CNT_W'(1))};

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == SLOT_AW'(SLOT_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            item            <= req_word;
            limit           <= radius_sq;
            issue_pos       <= SLOT_AW'(req_word.entry_index);
            issue_left      <= count;
            res.found_index <= '0;
            res.found_x     <= '0;
            res.found_y     <= '0;
            res.found_z     <= '0;
            unique case (req_word.command)
              CMD_LOAD: begin
                res.status <= load_ok ? ST_OK : ST_RANGE;
                state      <= S_DONE;
              end
              CMD_FIND: begin
                if (count == '0) begin
                  res.status <= ST_NONE;
                  state      <= S_DONE;
                end else if (!idx_ok) begin
                  res.status <= ST_RANGE;
                  state      <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              CMD_RELEASE: begin
                if (!idx_ok) begin
                  res.status <= ST_RANGE;
                  state      <= S_DONE;
                end else begin
                  state <= S_REL;
                end
              end
              default: begin
                res.status <= ST_RANGE;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (issue_v) begin
            issue_left <= issue_left - 1'b1;
            issue_pos  <= issue_pos_next;
          end
          if (hit) begin
            res.status      <= ST_OK;
            res.found_index <= IDX_W'(d_tag.pos);
            res.found_x     <= d_slot.x;
            res.found_y     <= d_slot.y;
            res.found_z     <= d_slot.z;
            state           <= S_DONE;
          end else if (miss_end) begin
            res.status <= ST_NONE;
            state      <= S_DONE;
          end
        end
        S_REL: begin
          res.status <= ram_rdata.mark ? ST_OK : ST_WAS_FREE;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            rsp_word <= res;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/ssrt_check.sv
// ----------------------------------------------------------------------------
// Slot reservation table port checks
// Concurrent checks on the top level's ports, bound to the top level.
// ----------------------------------------------------------------------------
module ssrt_check import ssrt_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_stall,
  input logic             rsp_valid,
  input logic             rsp_stall,
  input rsp_t             rsp_word
);

  // A response word that is held back keeps its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
    else $error("response word changed while stalled");

  // Requests are taken one at a time.
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second request taken in back-to-back cycles");

  // The mark sweep after reset keeps the request side stalled.
  a_clear_sweep: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> req_stall)
    else $error("request side open right after reset");

  // Only a successful find carries a slot index and position.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_word.status != ST_OK) |->
      (rsp_word.found_index == '0) && (rsp_word.found_x == '0) &&
      (rsp_word.found_y == '0) && (rsp_word.found_z == '0))
    else $error("failed request returned slot data");

endmodule

bind spatial_slot_reservation_table ssrt_check u_check (.*);

FILE: verif/slot_table_scoreboard.sv
// ----------------------------------------------------------------------------
// Slot table scoreboard
// Keeps a private copy of the slot table, works out the answer word for each
// accepted request word and compares it with what the table returns.
// ----------------------------------------------------------------------------
package slot_table_tb_pkg;
  import ssrt_pkg::*;

  // Command code that the table does not define.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  class slot_table_scoreboard;
    logic signed [COORD_W-1:0] slot_x [SLOT_DEPTH];
    logic signed [COORD_W-1:0] slot_y [SLOT_DEPTH];
    logic signed [COORD_W-1:0] slot_z [SLOT_DEPTH];
    bit                        busy   [SLOT_DEPTH];
    logic [CFG_W-1:0]          entry_count;
    rsp_t                      answers_due [$];
    int                        errors;
    int                        answered;
    int                        find_hits;
    int                        tally [4];

    function new();
      for (int i = 0; i < SLOT_DEPTH; i++) begin
        slot_x[i] = '0;
        slot_y[i] = '0;
        slot_z[i] = '0;
        busy[i]   = 1'b0;
      end
      entry_count = '0;
      errors      = 0;
      answered    = 0;
      find_hits   = 0;
      for (int i = 0; i < 4; i++) begin
        tally[i] = 0;
      end
    endfunction

    function void set_count(logic [CFG_W-1:0] value);
      entry_count = value;
    endfunction

    function int pending();
      return answers_due.size();
    endfunction

    // Applies one accepted request word to the table copy and queues the answer.
    function void take_request(req_t r);
      rsp_t        a;
      int unsigned active;
      int unsigned spot;
      longint      reach;
      longint      dx;
      longint      dy;
      longint      dz;
      bit          found;
      a      = '0;
      active = (entry_count > SLOT_DEPTH) ? SLOT_DEPTH : entry_count;
      case (r.command)
        CMD_LOAD: begin
          slot_x[r.entry_index] = r.point_x;
          slot_y[r.entry_index] = r.point_y;
          slot_z[r.entry_index] = r.point_z;
          busy[r.entry_index]   = 1'b0;
          a.status = ST_OK;
        end
        CMD_FIND: begin
          if (active == 0) begin
            a.status = ST_NONE;
          end else if (r.entry_index >= active) begin
            a.status = ST_RANGE;
          end else begin
            // Exact squared distances; three 48-bit squares fit a longint.
            reach    = longint'(r.max_distance) * longint'(r.max_distance);
            spot     = r.entry_index;
            found    = 1'b0;
            a.status = ST_NONE;
            for (int n = 0; n < active && !found; n++) begin
              dx = longint'(slot_x[spot]) - longint'(r.point_x);
              dy = longint'(slot_y[spot]) - longint'(r.point_y);
              dz = longint'(slot_z[spot]) - longint'(r.point_z);
              if ((r.max_distance == 0 || dx * dx + dy * dy + dz * dz <= reach) &&
                  !busy[spot]) begin
                found         = 1'b1;
                busy[spot]    = busy[spot] | r.set_mark;
                a.status      = ST_OK;
                a.found_index = IDX_W'(spot);
                a.found_x     = slot_x[spot];
                a.found_y     = slot_y[spot];
                a.found_z     = slot_z[spot];
                find_hits++;
              end else begin
                spot = (spot + 1 == active) ? 0 : spot + 1;
              end
            end
          end
        end
        CMD_RELEASE: begin
          if (r.entry_index >= active) begin
            a.status = ST_RANGE;
          end else begin
            a.status = busy[r.entry_index] ? ST_OK : ST_WAS_FREE;
            busy[r.entry_index] = 1'b0;
          end
        end
        default: begin
          a.status = ST_RANGE;
        end
      endcase
      tally[a.status]++;
      answers_due = {answers_due, a};
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) begin
        $display("tb: mismatch: %s", msg);
      end
    endtask

    task check_answer(rsp_t got);
      rsp_t want;
      if (answers_due.size() == 0) begin
        report($sformatf("answer word %h arrived with none outstanding", got));
        return;
      end
      want = answers_due.pop_front();
      answered++;
      if (got.status !== want.status) begin
        report($sformatf("answer %0d status %0d, wanted %0d", answered, got.status,
                         want.status));
      end
      if (got.found_index !== want.found_index) begin
        report($sformatf("answer %0d found_index %0d, wanted %0d", answered,
                         got.found_index, want.found_index));
      end
      if (got.found_x !== want.found_x) begin
        report($sformatf("answer %0d found_x %0d, wanted %0d", answered, got.found_x,
                         want.found_x));
      end
      if (got.found_y !== want.found_y) begin
        report($sformatf("answer %0d found_y %0d, wanted %0d", answered, got.found_y,
                         want.found_y));
      end
      if (got.found_z !== want.found_z) begin
        report($sformatf("answer %0d found_z %0d, wanted %0d", answered, got.found_z,
                         want.found_z));
      end
    endtask
  endclass

endpackage

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// Slot reservation table testbench
// Directed loads, finds and releases over the corner cases, then random
// traffic over a series of table sizes, with random gaps on the request side
// and random stalls on the answer side; every answer word is checked.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssrt_pkg::*;
  import slot_table_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int          PHASES      = 12;
  localparam int          PHASE_ITEMS = 100;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [COORD_W-1:0]        REACH_MAX = '1;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;
  logic             req_valid = 1'b0;
  logic             req_stall;
  req_t             req_word  = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  rsp_t             rsp_word;

  slot_table_scoreboard sb = new();

  bit          loaded [SLOT_DEPTH];
  bit          quiet      = 1'b0;
  int          stall_left = 0;
  int          requests   = 0;
  int unsigned cycles     = 0;
  int unsigned sizes [PHASES] = '{1, 256, 2, 37, 511, 3, 0, 300, 16, 0, 255, 5};

  spatial_slot_reservation_table DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // A new stall length is drawn for each answer word; it only runs down
  // while a word is actually waiting.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      sb.check_answer(rsp_word);
      stall_left = quiet ? 0 : $urandom_range(0, 3);
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      if (rsp_valid) begin
        stall_left = stall_left - 1;
      end
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: done, errors");
    $finish;
  end

  function automatic req_t make_req(logic [1:0] cmd, int idx, logic signed [COORD_W-1:0] x,
                                    logic signed [COORD_W-1:0] y,
                                    logic signed [COORD_W-1:0] z,
                                    logic [COORD_W-1:0] reach, bit mark);
    req_t r;
    r.command      = cmd;
    r.entry_index  = IDX_W'(idx);
    r.point_x      = x;
    r.point_y      = y;
    r.point_z      = z;
    r.max_distance = reach;
    r.set_mark     = mark;
    return r;
  endfunction

  // Most points sit in a small cluster so that the distance filter both
  // passes and rejects; the rest cover the full range and its ends.
  function automatic logic signed [COORD_W-1:0] random_coord();
    case ($urandom_range(0, 9))
      0: return COORD_W'($urandom);
      1: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      default: return COORD_W'(int'($urandom_range(0, 1200)) - 600);
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] random_reach();
    case ($urandom_range(0, 9))
      0, 1, 2: return '0;
      8: return COORD_W'($urandom);
      9: return $urandom_range(0, 1) ? REACH_MAX : COORD_W'(1);
      default: return COORD_W'($urandom_range(1, 900));
    endcase
  endfunction

  function automatic req_t random_request(int unsigned active);
    req_t        r;
    int unsigned pick;
    int          idx;
    pick = $urandom_range(0, 99);
    if (active > 0 && $urandom_range(0, 9) != 0) begin
      idx = $urandom_range(0, active - 1);
    end else begin
      idx = $urandom_range(0, SLOT_DEPTH - 1);
    end
    r = make_req(CMD_FIND, idx, random_coord(), random_coord(), random_coord(),
                 random_reach(), $urandom_range(0, 3) != 0);
    if (pick < 20) begin
      r.command = CMD_LOAD;
    end else if (pick < 65) begin
      r.command = CMD_FIND;
    end else if (pick < 96) begin
      r.command = CMD_RELEASE;
    end else begin
      r.command = CMD_UNUSED;
    end
    return r;
  endfunction

  // Starts at the edge where the previous word was taken, so valid is never
  // lowered and raised within one step.
  task automatic issue_request(input req_t w);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_word  <= w;
    do @(posedge clk); while (req_stall);
    sb.take_request(w);
    if (w.command == CMD_LOAD) begin
      loaded[w.entry_index] = 1'b1;
    end
    requests++;
  endtask

  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_count(input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_count(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Every slot that a find may scan must hold a position first.
  task automatic fill_table(input int unsigned active);
    for (int i = 0; i < active; i++) begin
      if (!loaded[i]) begin
        issue_request(make_req(CMD_LOAD, i, random_coord(), random_coord(), random_coord(),
                               random_reach(), $urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    int unsigned active;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty table, unknown command and loads beyond the table size.
    write_count('0);
    issue_request(make_req(CMD_FIND, 0, '0, '0, '0, '0, 1'b1));
    issue_request(make_req(CMD_RELEASE, 0, '0, '0, '0, '0, 1'b0));
    issue_request(make_req(CMD_UNUSED, 255, COORD_MIN, COORD_MAX, COORD_MIN, REACH_MAX, 1'b1));
    issue_request(make_req(CMD_LOAD, 255, COORD_MAX, COORD_MIN, '0, '0, 1'b0));
    issue_request(make_req(CMD_LOAD, 0, COORD_MIN, COORD_MIN, COORD_MIN, '0, 1'b0));
    issue_request(make_req(CMD_LOAD, 1, COORD_MAX, COORD_MAX, COORD_MAX, '0, 1'b0));
    issue_request(make_req(CMD_LOAD, 2, '0, '0, '0, '0, 1'b0));
    issue_request(make_req(CMD_LOAD, 3, 24'sd16, -24'sd16, 24'sd32, '0, 1'b0));
    drain();

    // Four slots: range errors, marking, distance filter, wrap and release.
    write_count(CFG_W'(4));
    issue_request(make_req(CMD_FIND, 4, '0, '0, '0, '0, 1'b1));
    issue_request(make_req(CMD_FIND, 255, '0, '0, '0, '0, 1'b1));
    issue_request(make_req(CMD_RELEASE, 0, '0, '0, '0, '0, 1'b0));
    issue_request(make_req(CMD_FIND, 2, '0, '0, '0, '0, 1'b1));
    issue_request(make_req(CMD_FIND, 2, '0, '0, '0, '0, 1'b0));
    issue_request(make_req(CMD_FIND, 3, '0, '0, '0, COORD_W'(1), 1'b1));
    issue_request(make_req(CMD_FIND, 0, COORD_MIN, COORD_MIN, COORD_MIN, REACH_MAX, 1'b1));
    issue_request(make_req(CMD_FIND, 0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_W'(1), 1'b1));
    issue_request(make_req(CMD_FIND, 1, '0, '0, '0, '0, 1'b1));
    issue_request(make_req(CMD_FIND, 0, '0, '0, '0, '0, 1'b1));
    issue_request(make_req(CMD_RELEASE, 2, '0, '0, '0, '0, 1'b0));
    issue_request(make_req(CMD_RELEASE, 2, '0, '0, '0, '0, 1'b0));
    issue_request(make_req(CMD_RELEASE, 4, '0, '0, '0, '0, 1'b0));
    issue_request(make_req(CMD_LOAD, 1, -24'sd1, 24'sd1, -24'sd1, '0, 1'b0));
    issue_request(make_req(CMD_FIND, 3, '0, '0, '0, '0, 1'b0));
    issue_request(make_req(CMD_RELEASE, 255, '0, '0, '0, '0, 1'b1));

    sizes[9] = $urandom_range(2, 255);
    for (int p = 0; p < PHASES; p++) begin
      drain();
      quiet = (p % 4 == 2);
      write_count(CFG_W'(sizes[p]));
      active = (sizes[p] > SLOT_DEPTH) ? SLOT_DEPTH : sizes[p];
      fill_table(active);
      repeat (PHASE_ITEMS) issue_request(random_request(active));
    end
    drain();
    repeat (16) @(posedge clk);

    $display("tb: %0d requests over %0d table sizes, %0d answers checked",
             requests, PHASES + 2, sb.answered);
    $display("tb: finds placed %0d, none free %0d, rejected %0d, released while free %0d",
             sb.find_hits, sb.tally[ST_NONE], sb.tally[ST_RANGE], sb.tally[ST_WAS_FREE]);
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: spatial_slot_reservation_table.f
hw/rtl/ssrt_pkg.sv
hw/rtl/ssrt_ram.sv
hw/rtl/ssrt_dist.sv
hw/rtl/spatial_slot_reservation_table.sv
hw/rtl/ssrt_check.sv
verif/slot_table_scoreboard.sv
verif/tb.sv
